### design/assert_macros.svh
// Assertion macros shared by the frame emitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define DSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold.
`define DSF_NEVER(label, cond, msg) \
    `DSF_ASSERT(label, !(cond), msg)

`endif

### design/dsf_pkg.sv
// Types, constants and glyph table for the decimal seven-segment frame emitter.
package dsf_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
    localparam int NUMBER_W     = 14;
    localparam int REP_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REP_W-1:0]    MAX_REPEAT   = 4'd15;
    localparam logic [NUMBER_W-1:0] NUM_MODULUS  = 14'd10000;
    localparam logic [NUMBER_W-1:0] LIMIT_TENS   = 14'd9;
    localparam logic [NUMBER_W-1:0] LIMIT_HUNDS  = 14'd99;
    localparam logic [NUMBER_W-1:0] LIMIT_THOUS  = 14'd999;

    localparam logic [BYTE_W-1:0] SEL_ONES  = 8'h01;
    localparam logic [BYTE_W-1:0] SEL_TENS  = 8'h02;
    localparam logic [BYTE_W-1:0] SEL_HUNDS = 8'h04;
    localparam logic [BYTE_W-1:0] SEL_THOUS = 8'h08;

    localparam logic OP_FOUR_DIGIT = 1'b0;
    localparam logic OP_TWO_DIGIT  = 1'b1;

    typedef logic [3:0] digit_t;

    // one decoded frame group, handed from front to back
    typedef struct packed {
        logic [NUM_DIGITS-1:0][BYTE_W-1:0] seg;
        logic [NUM_DIGITS-1:0][BYTE_W-1:0] sel;
        logic [DIGIT_IDX_W-1:0]            last_idx;
        logic [REP_W-1:0]                  rep;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [BYTE_W-1:0] glyph(input digit_t d);
        logic [BYTE_W-1:0] g;
        case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = 8'hFF;
        endcase
        return g;
    endfunction

endpackage

### design/dsf_queue.sv
// Two-entry queue of frame groups between front and back.
module dsf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dsf_pkg::group_t        push_group,
    input  logic                   pop,
    output dsf_pkg::group_t        head,
    output dsf_pkg::queue_status_t status
);
    import dsf_pkg::*;

    group_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/dsf_front.sv
// Front end: accepts a word, splits the number into digits, builds the frame group.
module dsf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [dsf_pkg::NUMBER_W-1:0] number,
    input  logic                         show_zero,
    input  logic [dsf_pkg::REP_W-1:0]    repeat_count,
    input  logic [dsf_pkg::BYTE_W-1:0]   position_mask,
    input  dsf_pkg::queue_status_t       q_status,
    output logic                         push,
    output dsf_pkg::group_t              push_group
);
    import dsf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_PUSH
    } state_t;

    state_t                 state_reg;
    logic [NUMBER_W-1:0]    x_reg;
    logic [NUMBER_W-1:0]    num_reg;
    logic                   mode_reg;
    logic                   zero_reg;
    logic [REP_W-1:0]       rep_reg;
    logic [BYTE_W-1:0]      mask_reg;
    digit_t                 digit_reg [NUM_DIGITS];
    logic [DIGIT_IDX_W-1:0] idx_reg;

    logic [NUMBER_W-1:0]    num_mod;
    logic [30:0]            prod;
    logic [NUMBER_W-1:0]    quot;
    logic [NUMBER_W-1:0]    rem;
    logic                   accept;
    logic                   show_t;
    logic                   show_h;
    logic                   show_k;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign push     = (state_reg == S_PUSH) && !q_status.full;

    // number modulo 10000: input stays below twice the modulus
    assign num_mod = (number >= NUM_MODULUS) ? number - NUM_MODULUS : number;

    // x / 10 by reciprocal, exact for 14-bit x
    assign prod = {17'b0, x_reg} * 31'd52429;
    assign quot = NUMBER_W'(prod[30:19]);
    assign rem  = x_reg - ((quot << 3) + (quot << 1));

    assign show_t = zero_reg || (num_reg > LIMIT_TENS);
    assign show_h = zero_reg || (num_reg > LIMIT_HUNDS);
    assign show_k = zero_reg || (num_reg > LIMIT_THOUS);

    always_comb
    begin
        push_group.rep = (rep_reg > MAX_REPEAT) ? MAX_REPEAT : rep_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            push_group.seg[i] = glyph(digit_reg[i]);
        end
        if (mode_reg == OP_TWO_DIGIT)
        begin
            push_group.sel[0]   = mask_reg;
            push_group.sel[1]   = {mask_reg[BYTE_W-2:0], 1'b0};
            push_group.sel[2]   = SEL_HUNDS;
            push_group.sel[3]   = SEL_THOUS;
            push_group.last_idx = DIGIT_IDX_W'(1);
        end
        else
        begin
            push_group.sel[0]   = SEL_ONES;
            push_group.sel[1]   = SEL_TENS;
            push_group.sel[2]   = SEL_HUNDS;
            push_group.sel[3]   = SEL_THOUS;
            // blanking conditions nest, so shown digits form a prefix
            push_group.last_idx = DIGIT_IDX_W'({1'b0, show_t} + {1'b0, show_h}
                                               + {1'b0, show_k});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            x_reg     <= '0;
            num_reg   <= '0;
            mode_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            rep_reg   <= '0;
            mask_reg  <= '0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg     <= num_mod;
                        num_reg   <= number;
                        mode_reg  <= opcode;
                        zero_reg  <= show_zero;
                        rep_reg   <= repeat_count;
                        mask_reg  <= position_mask;
                        idx_reg   <= '0;
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    digit_reg[idx_reg] <= rem[3:0];
                    x_reg              <= quot;
                    idx_reg            <= idx_reg + 1'b1;
                    if (idx_reg == DIGIT_IDX_W'(NUM_DIGITS - 1))
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (push)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/dsf_back.sv
// Back end: plays a frame group out one frame per cycle while out_ready is high, with repeats.
module dsf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dsf_pkg::group_t            head,
    input  dsf_pkg::queue_status_t     q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dsf_pkg::BYTE_W-1:0] segments,
    output logic [dsf_pkg::BYTE_W-1:0] digit_select,
    output logic                       last_frame
);
    import dsf_pkg::*;

    logic                   active_reg;
    group_t                 group_reg;
    logic [DIGIT_IDX_W-1:0] frame_reg;
    logic [REP_W-1:0]       rep_left_reg;
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      seg_reg;
    logic [BYTE_W-1:0]      sel_reg;
    logic                   last_reg;
    logic                   emit;
    logic                   group_end;
    logic                   burst_end;

    assign pop       = !active_reg && !q_status.empty;
    assign emit      = active_reg && (!out_valid_reg || out_ready);
    assign group_end = (frame_reg == group_reg.last_idx);
    assign burst_end = group_end && (rep_left_reg == '0);

    assign out_valid    = out_valid_reg;
    assign segments     = seg_reg;
    assign digit_select = sel_reg;
    assign last_frame   = last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            group_reg <= head;
        end
        if (emit)
        begin
            seg_reg  <= group_reg.seg[frame_reg];
            sel_reg  <= group_reg.sel[frame_reg];
            last_reg <= burst_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            frame_reg     <= '0;
            rep_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg   <= 1'b1;
                frame_reg    <= '0;
                rep_left_reg <= head.rep;
            end
            else if (emit)
            begin
                if (group_end)
                begin
                    frame_reg <= '0;
                    if (rep_left_reg == '0)
                    begin
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        rep_left_reg <= rep_left_reg - 1'b1;
                    end
                end
                else
                begin
                    frame_reg <= frame_reg + 1'b1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### design/decimal_seven_segment_frame_emitter.sv
// An accepted word is split into digits, queued as a frame group, popped and registered out.
// Throughput: within a group, one frame per cycle while out_ready is high; a word yields
// (1..4 frames) x (repeat_count+1), up to 64. The front takes a new word only after it has
// pushed the last one, stalling while the two-entry group queue is full, and the back end
// pops the next group only once it has played out the last one.
// Reset (rst_n, async, active low) empties the queue and idles both front and back.
`include "assert_macros.svh"

module decimal_seven_segment_frame_emitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [dsf_pkg::NUMBER_W-1:0] number,
    input  logic                         show_zero,
    input  logic [dsf_pkg::REP_W-1:0]    repeat_count,
    input  logic [dsf_pkg::BYTE_W-1:0]   position_mask,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dsf_pkg::BYTE_W-1:0]   segments,
    output logic [dsf_pkg::BYTE_W-1:0]   digit_select,
    output logic                         last_frame
);
    import dsf_pkg::*;

    logic          q_push;
    logic          q_pop;
    group_t        q_in;
    group_t        q_head;
    queue_status_t q_stat;

    dsf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .number        (number),
        .show_zero     (show_zero),
        .repeat_count  (repeat_count),
        .position_mask (position_mask),
        .q_status      (q_stat),
        .push          (q_push),
        .push_group    (q_in)
    );

    dsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_stat)
    );

    dsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_status     (q_stat),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .segments     (segments),
        .digit_select (digit_select),
        .last_frame   (last_frame)
    );

    `DSF_NEVER(a_push_when_full, q_push && q_stat.full, "group pushed into full queue")
    `DSF_NEVER(a_full_and_empty, q_stat.full && q_stat.empty, "queue full and empty")
    `DSF_ASSERT(a_dp_dark, out_valid |-> segments[7], "decimal point lit on output frame")

endmodule
